@@ design/acct_pkg.sv @@
// Package with shared constants, CORDIC angle table and types for the tilt-angle block.
package acct_pkg;

  localparam int AngleFracBitsDefault = 7;
  localparam int AccFrac = 16;
  localparam int CordicSteps = 18;
  // Sum of squares: up to 2^31, times 2^16 gives 48 bits; root is 24 bits.
  localparam int SqW = 48;
  localparam int RootW = 24;
  // CORDIC datapath width: x grows to about 1.65 * 2^24 with headroom.
  localparam int CW = 28;
  localparam int AccW = 24;

  typedef logic signed [CW-1:0] cval_t;
  typedef logic signed [AccW-1:0] acc_t;

  // Rounded atan(2^-i) in 2^-16 degree.
  function automatic acc_t atan_tab(input logic [4:0] i);
    acc_t r;
    r = '0;
    unique case (i)
      5'd0: r = 24'sd2949120;
      5'd1: r = 24'sd1740967;
      5'd2: r = 24'sd919879;
      5'd3: r = 24'sd466945;
      5'd4: r = 24'sd234379;
      5'd5: r = 24'sd117304;
      5'd6: r = 24'sd58666;
      5'd7: r = 24'sd29335;
      5'd8: r = 24'sd14668;
      5'd9: r = 24'sd7334;
      5'd10: r = 24'sd3667;
      5'd11: r = 24'sd1833;
      5'd12: r = 24'sd917;
      5'd13: r = 24'sd458;
      5'd14: r = 24'sd229;
      5'd15: r = 24'sd115;
      5'd16: r = 24'sd57;
      5'd17: r = 24'sd29;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

@@ design/acct_isqrt.sv @@
// Pipelined floor square root, one result bit per stage, with an enable for stalls.
module acct_isqrt import acct_pkg::*; #(
  parameter int InW = SqW,
  parameter int OutW = InW / 2,
  parameter int TagW = 1
) (
  input  logic            clk,
  input  logic            en,
  input  logic [InW-1:0]  din,
  input  logic [TagW-1:0] tag_in,
  output logic [OutW-1:0] root,
  output logic [InW-1:0]  rem,
  output logic [TagW-1:0] tag_out
);

  // Stage k decides root bit OutW-1-k by restoring subtraction.
  logic [InW-1:0]  rad_q  [OutW+1];
  logic [OutW-1:0] root_q [OutW+1];
  logic [InW-1:0]  rem_q  [OutW+1];
  logic [TagW-1:0] tag_q  [OutW+1];

  assign rad_q[0]  = din;
  assign root_q[0] = '0;
  assign rem_q[0]  = '0;
  assign tag_q[0]  = tag_in;

  for (genvar k = 0; k < OutW; k++) begin : g_stage
    logic [InW+1:0] rem_sh;
    logic [InW+1:0] trial;
    logic           fits;
    always_comb begin
      rem_sh = {rem_q[k], rad_q[k][InW-1 -: 2]};
      trial  = {{(InW+2-OutW-2){1'b0}}, root_q[k], 2'b01};
      fits   = rem_sh >= trial;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rad_q[k+1]  <= {rad_q[k][InW-3:0], 2'b00};
        root_q[k+1] <= {root_q[k][OutW-2:0], fits};
        rem_q[k+1]  <= fits ? InW'(rem_sh - trial) : InW'(rem_sh);
        tag_q[k+1]  <= tag_q[k];
      end
    end
  end

  assign root    = root_q[OutW];
  assign rem     = rem_q[OutW];
  assign tag_out = tag_q[OutW];

endmodule

@@ design/acct_cordic.sv @@
// Pipelined vectoring CORDIC giving atan2(num, den) in output angle units, clamped.
module acct_cordic import acct_pkg::*; #(
  parameter int AngleFracBits = AngleFracBitsDefault
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [CW-1:0] num,
  input  logic        [RootW-1:0] den,
  output logic signed [CW-1:0] angle
);

  localparam int RShift = AccFrac - AngleFracBits;
  localparam logic signed [CW-1:0] Ninety = CW'(90) <<< AngleFracBits;

  cval_t xq [CordicSteps+1];
  cval_t yq [CordicSteps+1];
  logic signed [AccW+1:0] aq [CordicSteps+1];
  logic [1:0] sq [CordicSteps+1]; // special: bit1 zero num, bit0 zero den

  assign xq[0] = cval_t'({{(CW-RootW){1'b0}}, den});
  assign yq[0] = num;
  assign aq[0] = '0;
  assign sq[0] = {num == '0, den == '0};

  // One micro-rotation per stage.
  for (genvar i = 0; i < CordicSteps; i++) begin : g_rot
    always_ff @(posedge clk) begin
      if (en) begin
        if (!yq[i][CW-1]) begin
          xq[i+1] <= xq[i] + (yq[i] >>> i);
          yq[i+1] <= yq[i] - (xq[i] >>> i);
          aq[i+1] <= aq[i] + (AccW+2)'(atan_tab(5'(i)));
        end else begin
          xq[i+1] <= xq[i] - (yq[i] >>> i);
          yq[i+1] <= yq[i] + (xq[i] >>> i);
          aq[i+1] <= aq[i] - (AccW+2)'(atan_tab(5'(i)));
        end
        sq[i+1] <= sq[i];
      end
    end
  end

  // Num sign rides along in its own pipeline, taken from the original y sign.
  logic nsign [CordicSteps+1];
  assign nsign[0] = num[CW-1];
  for (genvar i = 0; i < CordicSteps; i++) begin : g_sign
    always_ff @(posedge clk) begin
      if (en) nsign[i+1] <= nsign[i];
    end
  end

  // Round, clamp and handle the degenerate cases.
  logic signed [AccW+1:0] rnd;
  logic signed [CW-1:0]   r;
  always_comb begin
    rnd = (aq[CordicSteps] + ((AccW+2)'(1) <<< (RShift-1))) >>> RShift;
    r   = CW'(rnd);
    if (r > Ninety) r = Ninety;
    if (r < -Ninety) r = -Ninety;
    priority if (sq[CordicSteps][1]) angle = '0;
    else if (sq[CordicSteps][0]) angle = nsign[CordicSteps] ? -Ninety : Ninety;
    else angle = r;
  end

endmodule

@@ design/accel_tilt_angles.sv @@
// Top level: accelerometer sample to roll, pitch and tilt-from-normal angles.
// Usage: present acc_x/acc_y/acc_z with in_valid; a transfer happens when
// in_valid is high and in_stall is low. Results leave on out_valid with
// roll_angle, pitch_angle and tilt_normal; a transfer happens when out_valid
// is high and out_stall is low. Angles carry ANGLE_FRAC_BITS fraction bits.
// Throughput is one sample per cycle while the output is not stalled. The
// pipeline runs through registers for squaring and summing, the square
// root, 18 CORDIC stages plus one rounding register, a register squaring
// the angles, the final root and one output register. Above 9 fraction
// bits the final root grows by one stage for each extra bit.
// The whole pipeline advances as one; when out_stall holds a full output
// register, every stage holds and in_stall rises, so nothing is lost.
// Reset clears all valid bits; payload registers are not reset.
module accel_tilt_angles import acct_pkg::*; #(
  parameter int ANGLE_FRAC_BITS = AngleFracBitsDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] acc_x,
  input  logic signed [15:0] acc_y,
  input  logic signed [15:0] acc_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [14:0] roll_angle,
  output logic signed [14:0] pitch_angle,
  output logic        [13:0] tilt_normal
);

  // Full angle width before masking, and the width of the sum of squares.
  localparam int AngW = (ANGLE_FRAC_BITS + 8 > 16) ? ANGLE_FRAC_BITS + 8 : 16;
  localparam int SqTW = (2 * ANGLE_FRAC_BITS + 14 > 32) ? 2 * ANGLE_FRAC_BITS + 14 : 32;
  localparam int TRootW = SqTW / 2;
  localparam int Lat = 3 + RootW + CordicSteps + 1 + 1 + TRootW + 1;

  logic en;
  logic [Lat-1:0] vld;

  // Global enable: advance unless the output holds an untaken result.
  assign en = !(out_valid && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[Lat-2:0], in_valid};
    end
  end
  assign out_valid = vld[Lat-1];

  // Stage 1: register inputs.
  logic signed [15:0] x1, y1, z1;
  always_ff @(posedge clk) begin
    if (en) begin
      x1 <= acc_x;
      y1 <= acc_y;
      z1 <= acc_z;
    end
  end

  // Stage 2: squares.
  logic [31:0] xx2, yy2, zz2;
  logic signed [15:0] x2, y2;
  always_ff @(posedge clk) begin
    if (en) begin
      xx2 <= 32'(x1) * 32'(x1);
      yy2 <= 32'(y1) * 32'(y1);
      zz2 <= 32'(z1) * 32'(z1);
      x2  <= x1;
      y2  <= y1;
    end
  end

  // Stage 3: sums of squares scaled by 2^16.
  logic [SqW-1:0] sxz3, syz3;
  logic signed [15:0] x3, y3;
  always_ff @(posedge clk) begin
    if (en) begin
      sxz3 <= {SqW'({1'b0, xx2} + {1'b0, zz2})} << 16;
      syz3 <= {SqW'({1'b0, yy2} + {1'b0, zz2})} << 16;
      x3   <= x2;
      y3   <= y2;
    end
  end

  // Square roots for the two denominators; numerators ride as tags.
  logic [RootW-1:0] d_roll, d_pitch;
  logic [SqW-1:0]   rem_a, rem_b;
  logic [31:0]      tag_o;
  logic [15:0]      tag_unused;
  acct_isqrt #(.InW(SqW), .OutW(RootW), .TagW(32)) u_sqrt_roll (
    .clk(clk), .en(en), .din(sxz3), .tag_in({x3, y3}),
    .root(d_roll), .rem(rem_a), .tag_out(tag_o)
  );
  acct_isqrt #(.InW(SqW), .OutW(RootW), .TagW(16)) u_sqrt_pitch (
    .clk(clk), .en(en), .din(syz3), .tag_in(y3),
    .root(d_pitch), .rem(rem_b), .tag_out(tag_unused)
  );

  cval_t n_roll, n_pitch;
  always_comb begin
    n_roll  = cval_t'($signed(tag_o[15:0])) <<< 8;
    n_pitch = -(cval_t'($signed(tag_o[31:16])) <<< 8);
  end

  // Angle computation.
  cval_t roll_c, pitch_c;
  acct_cordic #(.AngleFracBits(ANGLE_FRAC_BITS)) u_cordic_roll (
    .clk(clk), .en(en), .num(n_roll), .den(d_roll), .angle(roll_c)
  );
  acct_cordic #(.AngleFracBits(ANGLE_FRAC_BITS)) u_cordic_pitch (
    .clk(clk), .en(en), .num(n_pitch), .den(d_pitch), .angle(pitch_c)
  );

  // Register angles, then square them.
  logic signed [AngW-1:0] ra, pa, rb, pb;
  logic [SqTW-1:0] rr, pp;
  logic [SqTW-1:0] ssum;
  always_ff @(posedge clk) begin
    if (en) begin
      ra <= roll_c[AngW-1:0];
      pa <= pitch_c[AngW-1:0];
      rr <= SqTW'(ra) * SqTW'(ra);
      pp <= SqTW'(pa) * SqTW'(pa);
      rb <= ra;
      pb <= pa;
    end
  end
  assign ssum = rr + pp;

  // Root of roll^2 + pitch^2 with the angles as tag.
  logic [TRootW-1:0] troot;
  logic [SqTW-1:0]   trem;
  logic [2*AngW-1:0] atag;
  acct_isqrt #(.InW(SqTW), .OutW(TRootW), .TagW(2*AngW)) u_sqrt_tilt (
    .clk(clk), .en(en), .din(ssum), .tag_in({rb, pb}),
    .root(troot), .rem(trem), .tag_out(atag)
  );

  // Output register with round-half-up of the root.
  logic [TRootW:0] tr;
  assign tr = (trem > SqTW'(troot)) ? {1'b0, troot} + 1'b1 : {1'b0, troot};
  always_ff @(posedge clk) begin
    if (en) begin
      roll_angle  <= atag[AngW+14:AngW];
      pitch_angle <= atag[14:0];
      tilt_normal <= tr[13:0];
    end
  end

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the accelerometer tilt-angle block.
module tb;
  import acct_pkg::*;

  localparam int FracBits = 7;
  localparam int Ninety = 90 << FracBits;
  localparam int Latency = 64;

  typedef struct packed {
    logic signed [14:0] roll;
    logic signed [14:0] pitch;
    logic [13:0] tilt;
  } angles_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] acc_x = '0;
  logic signed [15:0] acc_y = '0;
  logic signed [15:0] acc_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [14:0] roll_angle;
  logic signed [14:0] pitch_angle;
  logic [13:0] tilt_normal;

  angles_t expected_angles[$];
  int errors = 0;
  int samples_sent = 0;
  int results_seen = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_recv = 1'b0;

  accel_tilt_angles dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .acc_x(acc_x), .acc_y(acc_y), .acc_z(acc_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .roll_angle(roll_angle), .pitch_angle(pitch_angle), .tilt_normal(tilt_normal)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Floor integer square root.
  function automatic longint unsigned int_sqrt(input longint unsigned n);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  // Vectoring CORDIC atan2 for a nonnegative denominator, in output units.
  function automatic longint cordic_atan2(input longint num, input longint den);
    longint xv, yv, acc, dx, dy, r;
    longint tab[18] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                        29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29};
    if (num == 0) return 0;
    if (den == 0) return (num > 0) ? Ninety : -Ninety;
    xv = den;
    yv = num;
    acc = 0;
    for (int i = 0; i < 18; i++) begin
      dx = yv >>> i;
      dy = xv >>> i;
      if (yv >= 0) begin
        xv += dx; yv -= dy; acc += tab[i];
      end else begin
        xv -= dx; yv += dy; acc -= tab[i];
      end
    end
    r = (acc + (64'sd1 <<< (15 - FracBits))) >>> (16 - FracBits);
    if (r > Ninety) r = Ninety;
    if (r < -Ninety) r = -Ninety;
    return r;
  endfunction

  function automatic angles_t predict_angles(input logic signed [15:0] ax,
                                             input logic signed [15:0] ay,
                                             input logic signed [15:0] az);
    longint x, y, z, roll, pitch;
    longint unsigned sq, t;
    angles_t a;
    x = ax; y = ay; z = az;
    roll = cordic_atan2(y * 256, longint'(int_sqrt(longint'(x*x + z*z) << 16)));
    pitch = cordic_atan2(-x * 256, longint'(int_sqrt(longint'(y*y + z*z) << 16)));
    sq = roll * roll + pitch * pitch;
    t = int_sqrt(sq);
    if (sq - t * t > t) t++;
    a.roll = roll[14:0];
    a.pitch = pitch[14:0];
    a.tilt = t[13:0];
    return a;
  endfunction

  // Offer one sample, with a random gap first, and wait for its transfer.
  task automatic send_sample(input logic signed [15:0] x, input logic signed [15:0] y,
                             input logic signed [15:0] z);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    acc_x <= x;
    acc_y <= y;
    acc_z <= z;
    expected_angles.push_back(predict_angles(x, y, z));
    samples_sent++;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Receiver stall generation.
  always @(posedge clk) begin
    if (hold_recv) out_stall <= 1'b1;
    else out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Compare every result transfer with the oldest prediction.
  always @(posedge clk) begin
    angles_t e;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (expected_angles.size() == 0) begin
        $display("%0t: unexpected result roll=%0d pitch=%0d tilt=%0d", $time,
                 roll_angle, pitch_angle, tilt_normal);
        errors++;
      end else begin
        e = expected_angles.pop_front();
        if (roll_angle !== e.roll) begin
          $display("%0t: roll expected %0d got %0d", $time, e.roll, roll_angle);
          errors++;
        end
        if (pitch_angle !== e.pitch) begin
          $display("%0t: pitch expected %0d got %0d", $time, e.pitch, pitch_angle);
          errors++;
        end
        if (tilt_normal !== e.tilt) begin
          $display("%0t: tilt expected %0d got %0d", $time, e.tilt, tilt_normal);
          errors++;
        end
      end
    end
  end

  // Stop offering samples and wait until every expected result has arrived.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_angles.size() != 0) @(posedge clk);
  endtask

  // Axis extremes, zero cases and the most negative count.
  task automatic test_directed();
    logic signed [15:0] v[6] = '{16'sh8000, 16'sh7fff, 16'sd0, 16'sd1, -16'sd1, 16'sd16384};
    send_sample(16'sd0, 16'sd0, 16'sd0);
    send_sample(16'sh8000, 16'sd0, 16'sd0);
    send_sample(16'sh7fff, 16'sd0, 16'sd0);
    send_sample(16'sd0, 16'sh8000, 16'sd0);
    send_sample(16'sd0, 16'sh7fff, 16'sd0);
    send_sample(16'sd0, 16'sd0, 16'sh8000);
    send_sample(16'sd0, 16'sd0, 16'sh7fff);
    send_sample(16'sh8000, 16'sh8000, 16'sh8000);
    send_sample(16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_sample(16'sd1, -16'sd1, 16'sd0);
    send_sample(-16'sd1, 16'sd1, 16'sd1);
    for (int i = 0; i < 12; i++) send_sample(v[i % 6], v[(i + 2) % 6], v[(i * 5) % 6]);
  endtask

  // Random samples, mixing full-range, small-magnitude and zero values.
  task automatic test_random(input int count);
    logic signed [15:0] c[3];
    for (int n = 0; n < count; n++) begin
      for (int k = 0; k < 3; k++) begin
        case ($urandom_range(3))
          0: c[k] = 16'($urandom_range(40) - 20);
          1: c[k] = 16'sd0;
          default: c[k] = 16'($urandom);
        endcase
      end
      send_sample(c[0], c[1], c[2]);
    end
  endtask

  // Hold the receiver off long enough to fill the pipeline and stall the input.
  task automatic test_backpressure();
    int held;
    send_idle_pct = 0;
    hold_recv = 1'b1;
    fork
      begin
        held = 0;
        while (held < 150) begin
          @(posedge clk);
          held++;
        end
        hold_recv = 1'b0;
      end
      test_random(120);
    join
    wait_drained();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    wait_drained();
    send_idle_pct = 38; recv_idle_pct = 76;
    test_random(220);
    send_idle_pct = 76; recv_idle_pct = 38;
    test_random(220);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(180);
    test_backpressure();
    repeat (Latency + 10) @(posedge clk);
    $display("Ran %0d samples (axis extremes, zero cases, random, back-pressure);", samples_sent);
    $display("%0d results compared, %0d mismatches.", results_seen, errors);
    if (errors == 0 && expected_angles.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end
endmodule

@@ filelist.f @@
design/acct_pkg.sv
design/acct_isqrt.sv
design/acct_cordic.sv
design/accel_tilt_angles.sv
tb/tb.sv
